/* rtl/core/fha_pkg.sv */
// Package for the first-fit heap allocator.
// Holds the heap constants, the datapath operation codes and the controller state type.
// No dependencies.
package fha_pkg;

  localparam int unsigned HEAP_BYTES   = 8192;
  localparam int unsigned MAX_FREE     = 64;
  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned PAYLOAD_SKIP = HEADER_BYTES - 8;
  localparam int unsigned HDR_DEPTH    = HEAP_BYTES / ALIGN_BYTES;

  localparam int unsigned OFF_W   = 13;  // byte offset in the heap
  localparam int unsigned SIZE_W  = 14;  // block or extent size
  localparam int unsigned REQ_W   = 14;  // requested size
  localparam int unsigned ASZ_W   = 15;  // aligned request size
  localparam int unsigned SUM_W   = 17;  // room for offset + header + request
  localparam int unsigned ALIGN_LG = $clog2(ALIGN_BYTES);
  localparam int unsigned HIDX_W  = $clog2(HDR_DEPTH);
  localparam int unsigned EIDX_W  = $clog2(MAX_FREE);
  localparam int unsigned CNT_W   = EIDX_W + 1;

  localparam logic [ASZ_W-1:0] ALIGN_MASK = ~ASZ_W'(ALIGN_BYTES - 1);

  // Result codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_MEM    = 2'd1;
  localparam logic [1:0] ST_BAD_FREE  = 2'd2;
  localparam logic [1:0] ST_TBL_FULL  = 2'd3;

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
  } ext_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              alloc;
  } hdr_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_A_SPLIT,
    OP_A_SPLIT_HDR,
    OP_A_TAKE,
    OP_DEL,
    OP_BUMP,
    OP_F_CHECK,
    OP_F_HDR,
    OP_FJ_BOTH,
    OP_HDR_CLR_CUR,
    OP_HDR_SET_PREV_DEL,
    OP_FJ_PREV,
    OP_HDR_SET_PREV,
    OP_FJ_NEXT,
    OP_HDR_SET_CUR,
    OP_FULL,
    OP_INS_INIT,
    OP_INS,
    OP_INS_WRITE,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic in_free;
    logic act_free;
    logic scan_hit;
    logic scan_end;
    logic split_fit;
    logic sweep_done;
    logic bad_addr;
    logic hdr_alloc;
    logic join_prev;
    logic join_next;
    logic table_full;
    logic out_free;
  } sts_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_A_INIT,
    S_SCAN,
    S_A_HIT,
    S_A_SPLIT_HDR,
    S_DEL,
    S_BUMP,
    S_F_CHECK,
    S_F_HDR,
    S_F_JOIN,
    S_B_CLR,
    S_B_SET,
    S_P_SET,
    S_N_SET,
    S_INS,
    S_INS_WR,
    S_DONE
  } state_e;

endpackage

/* rtl/core/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator.
// Depends on fha_pkg, fha_ctrl and fha_dpath.
//
// Channel   Direction  Carries
// s_axis    in         request: tuser = action, tdata = req_size, payload_addr
// m_axis    out        result:  tuser = status, tdata = result_addr
//
// After reset all 1024 header memory entries are cleared, one entry a cycle;
// no request is taken during that pass.
// One request is worked at a time. An allocate's time grows with N, the number of
// free extents held, since the scan and any closing shift of the free extent memory
// move one entry a cycle. For a free, the scan stops at the insertion point and the
// insert or delete shift covers the rest of the list, so its time grows with N as
// well.
// A finished result waits in the output register; the next request is accepted
// meanwhile and only its completion stalls on m_axis_tready.
module first_fit_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [13:0] req_size, [26:14] payload_addr, rest zero
  input  logic [0:0]  s_axis_tuser,   // [0] action: 0 allocate, 1 free
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [12:0] result_addr, rest zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  fha_pkg::cmd_t cmd;
  fha_pkg::sts_t sts;
  logic [fha_pkg::OFF_W-1:0] result_addr;

  fha_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .s_ready_o (s_axis_tready)
  );

  fha_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_action_i       (s_axis_tuser[0]),
    .in_req_size_i     (s_axis_tdata[13:0]),
    .in_payload_addr_i (s_axis_tdata[26:14]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_status_o      (m_axis_tuser),
    .out_result_addr_o (result_addr)
  );

  assign m_axis_tdata = {3'b000, result_addr};

endmodule

/* rtl/core/fha_ctrl.sv */
// Controller state machine of the first-fit heap allocator.
// Depends on fha_pkg; drives at most one datapath operation per cycle.
module fha_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  fha_pkg::sts_t sts_i,
  output fha_pkg::cmd_t cmd_o,
  output logic          s_ready_o
);

  fha_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fha_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = fha_pkg::OP_NONE;
    s_ready_o = 1'b0;
    unique case (state_q)
      fha_pkg::S_CLEAR: begin
        cmd_o.op = fha_pkg::OP_CLEAR;
        if (sts_i.clear_done) state_d = fha_pkg::S_IDLE;
      end
      fha_pkg::S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.op = fha_pkg::OP_LOAD;
          state_d  = sts_i.in_free ? fha_pkg::S_F_CHECK : fha_pkg::S_A_INIT;
        end
      end
      fha_pkg::S_A_INIT: begin
        cmd_o.op = fha_pkg::OP_SCAN_INIT;
        state_d  = fha_pkg::S_SCAN;
      end
      fha_pkg::S_SCAN: begin
        cmd_o.op = fha_pkg::OP_SCAN;
        if (sts_i.scan_hit) begin
          state_d = sts_i.act_free ? fha_pkg::S_F_JOIN : fha_pkg::S_A_HIT;
        end else if (sts_i.scan_end) begin
          state_d = sts_i.act_free ? fha_pkg::S_F_JOIN : fha_pkg::S_BUMP;
        end
      end
      fha_pkg::S_A_HIT: begin
        if (sts_i.split_fit) begin
          cmd_o.op = fha_pkg::OP_A_SPLIT;
          state_d  = fha_pkg::S_A_SPLIT_HDR;
        end else begin
          cmd_o.op = fha_pkg::OP_A_TAKE;
          state_d  = fha_pkg::S_DEL;
        end
      end
      fha_pkg::S_A_SPLIT_HDR: begin
        cmd_o.op = fha_pkg::OP_A_SPLIT_HDR;
        state_d  = fha_pkg::S_DONE;
      end
      fha_pkg::S_DEL: begin
        cmd_o.op = fha_pkg::OP_DEL;
        if (sts_i.sweep_done) state_d = fha_pkg::S_DONE;
      end
      fha_pkg::S_BUMP: begin
        cmd_o.op = fha_pkg::OP_BUMP;
        state_d  = fha_pkg::S_DONE;
      end
      fha_pkg::S_F_CHECK: begin
        cmd_o.op = fha_pkg::OP_F_CHECK;
        state_d  = sts_i.bad_addr ? fha_pkg::S_DONE : fha_pkg::S_F_HDR;
      end
      fha_pkg::S_F_HDR: begin
        cmd_o.op = fha_pkg::OP_F_HDR;
        state_d  = sts_i.hdr_alloc ? fha_pkg::S_SCAN : fha_pkg::S_DONE;
      end
      fha_pkg::S_F_JOIN: begin
        if (sts_i.join_prev && sts_i.join_next) begin
          cmd_o.op = fha_pkg::OP_FJ_BOTH;
          state_d  = fha_pkg::S_B_CLR;
        end else if (sts_i.join_prev) begin
          cmd_o.op = fha_pkg::OP_FJ_PREV;
          state_d  = fha_pkg::S_P_SET;
        end else if (sts_i.join_next) begin
          cmd_o.op = fha_pkg::OP_FJ_NEXT;
          state_d  = fha_pkg::S_N_SET;
        end else if (sts_i.table_full) begin
          cmd_o.op = fha_pkg::OP_FULL;
          state_d  = fha_pkg::S_DONE;
        end else begin
          cmd_o.op = fha_pkg::OP_INS_INIT;
          state_d  = fha_pkg::S_INS;
        end
      end
      fha_pkg::S_B_CLR: begin
        cmd_o.op = fha_pkg::OP_HDR_CLR_CUR;
        state_d  = fha_pkg::S_B_SET;
      end
      fha_pkg::S_B_SET: begin
        cmd_o.op = fha_pkg::OP_HDR_SET_PREV_DEL;
        state_d  = fha_pkg::S_DEL;
      end
      fha_pkg::S_P_SET: begin
        cmd_o.op = fha_pkg::OP_HDR_SET_PREV;
        state_d  = fha_pkg::S_DONE;
      end
      fha_pkg::S_N_SET: begin
        cmd_o.op = fha_pkg::OP_HDR_SET_CUR;
        state_d  = fha_pkg::S_DONE;
      end
      fha_pkg::S_INS: begin
        cmd_o.op = fha_pkg::OP_INS;
        if (sts_i.sweep_done) state_d = fha_pkg::S_INS_WR;
      end
      fha_pkg::S_INS_WR: begin
        cmd_o.op = fha_pkg::OP_INS_WRITE;
        state_d  = fha_pkg::S_DONE;
      end
      fha_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = fha_pkg::OP_OUT;
          state_d  = fha_pkg::S_IDLE;
        end
      end
      default: state_d = fha_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/core/fha_dpath.sv */
// Datapath of the first-fit heap allocator: header memory, free extent memory,
// scan and shift counters, and the output register. Depends on fha_pkg.
module fha_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fha_pkg::cmd_t               cmd_i,
  output fha_pkg::sts_t               sts_o,
  input  logic                        in_action_i,
  input  logic [fha_pkg::REQ_W-1:0]   in_req_size_i,
  input  logic [fha_pkg::OFF_W-1:0]   in_payload_addr_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  out_status_o,
  output logic [fha_pkg::OFF_W-1:0]   out_result_addr_o
);

  localparam int unsigned SW = fha_pkg::SUM_W;
  localparam int unsigned OW = fha_pkg::OFF_W;
  localparam int unsigned ZW = fha_pkg::SIZE_W;
  localparam int unsigned CW = fha_pkg::CNT_W;
  localparam int unsigned EW = fha_pkg::EIDX_W;
  localparam int unsigned HW = fha_pkg::HIDX_W;
  localparam int unsigned AL = fha_pkg::ALIGN_LG;

  // Memories.
  fha_pkg::hdr_t hdr_mem [fha_pkg::HDR_DEPTH];
  fha_pkg::ext_t ext_mem [fha_pkg::MAX_FREE];

  fha_pkg::hdr_t hdr_rd_q;
  fha_pkg::ext_t ext_rd_q;

  logic          hdr_we, ext_we, ext_re;
  logic [HW-1:0] hdr_wa, hdr_ra;
  fha_pkg::hdr_t hdr_wd;
  logic [EW-1:0] ext_wa, ext_ra;
  fha_pkg::ext_t ext_wd;

  // Item registers.
  logic                      act_q;
  logic [fha_pkg::ASZ_W-1:0] asize_q;
  logic [OW-1:0]             paddr_q, blk_q;
  logic [ZW-1:0]             bsize_q;

  // Free list registers.
  logic [CW-1:0] count_q, idx_q, rd_idx_q, pos_q;
  logic          rd_vld_q;
  fha_pkg::ext_t prev_q, cur_q;
  logic          prev_vld_q, cur_vld_q;
  logic [ZW:0]   bump_q;
  logic [HW-1:0] clr_q;

  // Result registers.
  logic [1:0]    res_status_q;
  logic [OW-1:0] res_addr_q;
  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic [OW-1:0] out_addr_q;

  // Arithmetic.
  logic [SW-1:0]             need, bump_need, prev_end, blk_end, merged_both, merged_prev;
  logic [SW-1:0]             merged_next;
  logic [fha_pkg::ASZ_W-1:0] in_asize;
  logic                      scan_cond, scan_hit, scan_end;
  logic                      dn_more, up_more, sweep_done;
  logic                      bad_addr;
  fha_pkg::ext_t             split_ext;

  assign in_asize = (fha_pkg::ASZ_W'(in_req_size_i) + fha_pkg::ASZ_W'(fha_pkg::ALIGN_BYTES - 1))
                    & fha_pkg::ALIGN_MASK;
  assign need        = SW'(asize_q) + SW'(fha_pkg::HEADER_BYTES);
  assign bump_need   = SW'(bump_q) + need;
  assign prev_end    = SW'(prev_q.off) + SW'(fha_pkg::HEADER_BYTES) + SW'(prev_q.size);
  assign blk_end     = SW'(blk_q) + SW'(fha_pkg::HEADER_BYTES) + SW'(bsize_q);
  assign merged_prev = SW'(prev_q.size) + SW'(fha_pkg::HEADER_BYTES) + SW'(bsize_q);
  assign merged_both = merged_prev + SW'(fha_pkg::HEADER_BYTES) + SW'(cur_q.size);
  assign merged_next = SW'(cur_q.size) + SW'(fha_pkg::HEADER_BYTES) + SW'(bsize_q);
  assign split_ext.off  = OW'(SW'(cur_q.off) + need);
  assign split_ext.size = ZW'(SW'(cur_q.size) - need);

  assign scan_cond = act_q ? (ext_rd_q.off > blk_q)
                           : (fha_pkg::ASZ_W'(ext_rd_q.size) >= asize_q);
  assign scan_hit  = rd_vld_q && scan_cond;
  assign scan_end  = !rd_vld_q && (idx_q >= count_q);
  assign dn_more   = idx_q < count_q;
  assign up_more   = idx_q > pos_q;
  assign sweep_done = !rd_vld_q && ((cmd_i.op == fha_pkg::OP_INS) ? !up_more : !dn_more);
  assign bad_addr  = (paddr_q < OW'(fha_pkg::PAYLOAD_SKIP)) || (blk_q[AL-1:0] != '0);

  assign sts_o.clear_done = (clr_q == HW'(fha_pkg::HDR_DEPTH - 1));
  assign sts_o.in_free    = in_action_i;
  assign sts_o.act_free   = act_q;
  assign sts_o.scan_hit   = scan_hit;
  assign sts_o.scan_end   = scan_end;
  assign sts_o.split_fit  = SW'(cur_q.size) > need;
  assign sts_o.sweep_done = sweep_done;
  assign sts_o.bad_addr   = bad_addr;
  assign sts_o.hdr_alloc  = hdr_rd_q.alloc;
  assign sts_o.join_prev  = prev_vld_q && (prev_end == SW'(blk_q));
  assign sts_o.join_next  = cur_vld_q && (blk_end == SW'(cur_q.off));
  assign sts_o.table_full = count_q >= CW'(fha_pkg::MAX_FREE);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Memory port selection.
  always_comb begin
    hdr_we = 1'b0;
    hdr_wa = blk_q[OW-1:AL];
    hdr_wd = '0;
    hdr_ra = blk_q[OW-1:AL];
    ext_we = 1'b0;
    ext_wa = pos_q[EW-1:0];
    ext_wd = cur_q;
    ext_re = 1'b0;
    ext_ra = idx_q[EW-1:0];
    case (cmd_i.op)
      fha_pkg::OP_CLEAR: begin
        hdr_we = 1'b1;
        hdr_wa = clr_q;
      end
      fha_pkg::OP_SCAN, fha_pkg::OP_DEL: begin
        ext_re = dn_more;
        if (cmd_i.op == fha_pkg::OP_DEL) begin
          ext_we = rd_vld_q;
          ext_wa = EW'(rd_idx_q - CW'(1));
          ext_wd = ext_rd_q;
        end
      end
      fha_pkg::OP_INS: begin
        ext_re = up_more;
        ext_ra = EW'(idx_q - CW'(1));
        ext_we = rd_vld_q;
        ext_wa = EW'(rd_idx_q + CW'(1));
        ext_wd = ext_rd_q;
      end
      fha_pkg::OP_A_SPLIT: begin
        ext_we = 1'b1;
        ext_wd = split_ext;
        hdr_we = 1'b1;
        hdr_wa = split_ext.off[OW-1:AL];
        hdr_wd = '{size: split_ext.size, alloc: 1'b0};
      end
      fha_pkg::OP_A_SPLIT_HDR: begin
        hdr_we = 1'b1;
        hdr_wa = cur_q.off[OW-1:AL];
        hdr_wd = '{size: ZW'(asize_q), alloc: 1'b1};
      end
      fha_pkg::OP_A_TAKE: begin
        hdr_we = 1'b1;
        hdr_wa = cur_q.off[OW-1:AL];
        hdr_wd = '{size: cur_q.size, alloc: 1'b1};
      end
      fha_pkg::OP_BUMP: begin
        hdr_we = !(bump_need > SW'(fha_pkg::HEAP_BYTES));
        hdr_wa = bump_q[OW-1:AL];
        hdr_wd = '{size: ZW'(asize_q), alloc: 1'b1};
      end
      fha_pkg::OP_FJ_BOTH: begin
        ext_we = 1'b1;
        ext_wa = EW'(pos_q - CW'(1));
        ext_wd = '{off: prev_q.off, size: ZW'(merged_both)};
        hdr_we = 1'b1;
      end
      fha_pkg::OP_FJ_PREV: begin
        ext_we = 1'b1;
        ext_wa = EW'(pos_q - CW'(1));
        ext_wd = '{off: prev_q.off, size: ZW'(merged_prev)};
        hdr_we = 1'b1;
      end
      fha_pkg::OP_HDR_CLR_CUR: begin
        hdr_we = 1'b1;
        hdr_wa = cur_q.off[OW-1:AL];
      end
      fha_pkg::OP_HDR_SET_PREV, fha_pkg::OP_HDR_SET_PREV_DEL: begin
        hdr_we = 1'b1;
        hdr_wa = prev_q.off[OW-1:AL];
        hdr_wd = '{size: prev_q.size, alloc: 1'b0};
      end
      fha_pkg::OP_FJ_NEXT: begin
        hdr_we = 1'b1;
        hdr_wa = cur_q.off[OW-1:AL];
        ext_we = 1'b1;
        ext_wd = '{off: blk_q, size: ZW'(merged_next)};
      end
      fha_pkg::OP_HDR_SET_CUR: begin
        hdr_we = 1'b1;
        hdr_wa = cur_q.off[OW-1:AL];
        hdr_wd = '{size: cur_q.size, alloc: 1'b0};
      end
      fha_pkg::OP_INS_WRITE: begin
        ext_we = 1'b1;
        ext_wd = '{off: blk_q, size: bsize_q};
        hdr_we = 1'b1;
        hdr_wd = '{size: bsize_q, alloc: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    hdr_rd_q <= hdr_mem[hdr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ext_we) ext_mem[ext_wa] <= ext_wd;
    if (ext_re) ext_rd_q <= ext_mem[ext_ra];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      fha_pkg::OP_LOAD: begin
        act_q   <= in_action_i;
        asize_q <= in_asize;
        paddr_q <= in_payload_addr_i;
        blk_q   <= in_payload_addr_i - OW'(fha_pkg::PAYLOAD_SKIP);
      end
      fha_pkg::OP_F_HDR: bsize_q <= hdr_rd_q.size;
      fha_pkg::OP_SCAN: begin
        if (scan_hit) begin
          cur_q <= ext_rd_q;
        end else if (rd_vld_q) begin
          prev_q <= ext_rd_q;
        end
      end
      fha_pkg::OP_FJ_BOTH: prev_q.size <= ZW'(merged_both);
      fha_pkg::OP_FJ_PREV: prev_q.size <= ZW'(merged_prev);
      fha_pkg::OP_FJ_NEXT: cur_q <= '{off: blk_q, size: ZW'(merged_next)};
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      bump_q       <= '0;
      clr_q        <= '0;
      idx_q        <= '0;
      rd_idx_q     <= '0;
      pos_q        <= '0;
      rd_vld_q     <= 1'b0;
      prev_vld_q   <= 1'b0;
      cur_vld_q    <= 1'b0;
      res_status_q <= fha_pkg::ST_OK;
      res_addr_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= fha_pkg::ST_OK;
      out_addr_q   <= '0;
    end else begin
      if (out_ready_i && (cmd_i.op != fha_pkg::OP_OUT)) out_valid_q <= 1'b0;
      case (cmd_i.op)
        fha_pkg::OP_CLEAR: clr_q <= clr_q + HW'(1);
        fha_pkg::OP_LOAD: begin
          res_status_q <= fha_pkg::ST_OK;
          res_addr_q   <= '0;
        end
        fha_pkg::OP_SCAN_INIT: begin
          idx_q      <= '0;
          rd_vld_q   <= 1'b0;
          prev_vld_q <= 1'b0;
        end
        fha_pkg::OP_SCAN: begin
          rd_vld_q <= dn_more;
          rd_idx_q <= idx_q;
          if (dn_more) idx_q <= idx_q + CW'(1);
          if (scan_hit) begin
            pos_q     <= rd_idx_q;
            cur_vld_q <= 1'b1;
          end else if (scan_end) begin
            pos_q     <= count_q;
            cur_vld_q <= 1'b0;
          end else if (rd_vld_q) begin
            prev_vld_q <= 1'b1;
          end
        end
        fha_pkg::OP_A_SPLIT_HDR: begin
          res_addr_q <= OW'(SW'(cur_q.off) + SW'(fha_pkg::PAYLOAD_SKIP));
        end
        fha_pkg::OP_A_TAKE: begin
          res_addr_q <= OW'(SW'(cur_q.off) + SW'(fha_pkg::PAYLOAD_SKIP));
          idx_q      <= pos_q + CW'(1);
          rd_vld_q   <= 1'b0;
        end
        fha_pkg::OP_HDR_SET_PREV_DEL: begin
          idx_q    <= pos_q + CW'(1);
          rd_vld_q <= 1'b0;
        end
        fha_pkg::OP_DEL: begin
          rd_vld_q <= dn_more;
          rd_idx_q <= idx_q;
          if (dn_more) idx_q <= idx_q + CW'(1);
          if (sweep_done) count_q <= count_q - CW'(1);
        end
        fha_pkg::OP_BUMP: begin
          if (bump_need > SW'(fha_pkg::HEAP_BYTES)) begin
            res_status_q <= fha_pkg::ST_NO_MEM;
          end else begin
            res_addr_q <= OW'(SW'(bump_q) + SW'(fha_pkg::PAYLOAD_SKIP));
            bump_q     <= (ZW+1)'(bump_need);
          end
        end
        fha_pkg::OP_F_CHECK: begin
          if (bad_addr) res_status_q <= fha_pkg::ST_BAD_FREE;
        end
        fha_pkg::OP_F_HDR: begin
          if (!hdr_rd_q.alloc) res_status_q <= fha_pkg::ST_BAD_FREE;
          idx_q      <= '0;
          rd_vld_q   <= 1'b0;
          prev_vld_q <= 1'b0;
        end
        fha_pkg::OP_FULL: res_status_q <= fha_pkg::ST_TBL_FULL;
        fha_pkg::OP_INS_INIT: begin
          idx_q    <= count_q;
          rd_vld_q <= 1'b0;
        end
        fha_pkg::OP_INS: begin
          rd_vld_q <= up_more;
          rd_idx_q <= idx_q - CW'(1);
          if (up_more) idx_q <= idx_q - CW'(1);
        end
        fha_pkg::OP_INS_WRITE: count_q <= count_q + CW'(1);
        fha_pkg::OP_OUT: begin
          out_valid_q  <= 1'b1;
          out_status_q <= res_status_q;
          out_addr_q   <= res_addr_q;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_result_addr_o = out_addr_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(fha_pkg::MAX_FREE))
    else $error("free extent count above table depth");

  a_bump_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= (ZW+1)'(fha_pkg::HEAP_BYTES))
    else $error("bump pointer beyond heap");

  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == fha_pkg::OP_INS_WRITE |-> count_q < CW'(fha_pkg::MAX_FREE))
    else $error("insert into full extent table");

  a_out_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == fha_pkg::OP_OUT |=> out_valid_q)
    else $error("result not presented after completion");

endmodule
